FILE: src/cda_pkg.sv
// Shared types and constants of the Canberra distance accumulator.
`default_nettype none
package cda_pkg;

	localparam int VALUE_BITS_DEF = 16;
	localparam int FRAC_BITS      = 16;
	localparam int QUO_BITS       = FRAC_BITS + 1;
	localparam int SUM_BITS       = 28;
	localparam int DIV_STEPS      = FRAC_BITS;
	localparam int CNT_BITS       = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_ACC
	} cda_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic accum;
		logic emit;
	} cda_cmd_t;

	typedef struct packed {
		logic last;
	} cda_stat_t;

endpackage
`default_nettype wire

FILE: src/canberra_distance_accumulator.sv
// An accepted item is loaded and divided by a restoring divider, one quotient bit per
// cycle, then summed; a last element also writes the result register, and waits while
// an earlier result is untaken. A new item is taken only once the last one is summed.
// The result register lets the next item run while a result waits.
// Reset (arst_n low) clears the sum, the saturation flag and all handshakes.
`default_nettype none
module canberra_distance_accumulator import cda_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [VALUE_BITS-1:0] a_value,
	input  wire logic [VALUE_BITS-1:0] b_value,
	input  wire logic                  last_element,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [SUM_BITS-1:0]        distance,
	output logic                       overflowed
);

	cda_cmd_t  cmd;
	cda_stat_t stat;

	cda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	cda_datapath #(
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.a_value      (a_value),
		.b_value      (b_value),
		.last_element (last_element),
		.cmd          (cmd),
		.stat         (stat),
		.distance     (distance),
		.overflowed   (overflowed)
	);

endmodule
`default_nettype wire

FILE: src/cda_datapath.sv
// Datapath: restoring divider for one term, saturating sum and result register.
`default_nettype none
module cda_datapath import cda_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [VALUE_BITS-1:0] a_value,
	input  wire logic [VALUE_BITS-1:0] b_value,
	input  wire logic                  last_element,
	input  wire cda_cmd_t              cmd,
	output cda_stat_t                  stat,
	output logic [SUM_BITS-1:0]        distance,
	output logic                       overflowed
);

	localparam int DEN_BITS = VALUE_BITS + 1;
	localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

	logic [DEN_BITS-1:0] den_q;
	logic [DEN_BITS-1:0] rem_q;
	logic [QUO_BITS-1:0] quo_q;
	logic                last_q;
	logic [SUM_BITS-1:0] sum_q;
	logic                sat_q;
	logic [SUM_BITS-1:0] distance_q;
	logic                overflowed_q;

	logic [DEN_BITS-1:0] diff;
	logic [DEN_BITS-1:0] den_raw;
	logic [DEN_BITS-1:0] den_eff;
	logic                first_ge;
	logic [DEN_BITS:0]   trial;
	logic                trial_ge;
	logic [SUM_BITS:0]   sum_ext;
	logic [SUM_BITS-1:0] sum_next;
	logic                sat_next;

	always_comb begin
		diff    = (a_value >= b_value) ? {1'b0, a_value - b_value} : {1'b0, b_value - a_value};
		den_raw = {1'b0, a_value} + {1'b0, b_value};
		// both zero: divide by one, so the term is zero
		den_eff  = (den_raw == '0) ? DEN_BITS'(1) : den_raw;
		first_ge = (diff >= den_eff);
		trial    = {rem_q, 1'b0};
		trial_ge = (trial >= {1'b0, den_q});
		sum_ext  = {1'b0, sum_q} + (SUM_BITS + 1)'(quo_q);
		sum_next = sum_ext[SUM_BITS] ? SUM_MAX : sum_ext[SUM_BITS-1:0];
		sat_next = sat_q | sum_ext[SUM_BITS];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			den_q  <= den_eff;
			rem_q  <= first_ge ? (diff - den_eff) : diff;
			quo_q  <= QUO_BITS'(first_ge);
			last_q <= last_element;
		end else if (cmd.step) begin
			rem_q <= trial_ge ? DEN_BITS'(trial - {1'b0, den_q}) : trial[DEN_BITS-1:0];
			quo_q <= {quo_q[QUO_BITS-2:0], trial_ge};
		end
		if (cmd.emit) begin
			distance_q   <= sum_next;
			overflowed_q <= sat_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			sat_q <= 1'b0;
		end else if (cmd.accum) begin
			// clear after the last element of a vector
			sum_q <= last_q ? '0 : sum_next;
			sat_q <= last_q ? 1'b0 : sat_next;
		end
	end

	assign stat.last  = last_q;
	assign distance   = distance_q;
	assign overflowed = overflowed_q;

endmodule
`default_nettype wire

FILE: src/cda_ctrl.sv
// Controller: sequences load, divide steps and accumulation, owns the handshakes.
`default_nettype none
module cda_ctrl import cda_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire cda_stat_t stat,
	output cda_cmd_t       cmd
);

	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIV_STEPS - 1);

	cda_state_t          state_q, state_d;
	logic [CNT_BITS-1:0] cnt_q;
	logic                out_valid_q;
	logic                out_block;

	assign out_block = stat.last && out_valid_q && !out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_DIV;
			ST_DIV:  if (cnt_q == CNT_LAST) state_d = ST_ACC;
			ST_ACC:  if (!out_block) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DIV: cmd.step = 1'b1;
			ST_ACC: begin
				cmd.accum = !out_block;
				cmd.emit  = !out_block && stat.last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_q == ST_DIV) ? cnt_q + 1'b1 : '0;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid_q && !out_ready))
		else $error("result overwritten before it was taken");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == CNT_LAST) |=> (state_q == ST_ACC))
		else $error("divide did not end after its last step");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_DIV && cnt_q == '0))
		else $error("accepted item did not start a divide");

endmodule
`default_nettype wire

FILE: tb/sv/canberra_distance_accumulator_tb.sv
// Self-checking testbench for the Canberra distance accumulator, with a local sum model.
`timescale 1ns / 100ps
module canberra_distance_accumulator_tb;
	import cda_pkg::*;

	localparam int VW               = VALUE_BITS_DEF;
	localparam int IDLE_LIMIT       = 2000;
	localparam int HOLD_CYCLES      = 400;
	localparam int RANDOM_PER_PHASE = 300;
	localparam int PRESSURE_ITEMS   = 40;
	localparam int DRAIN_CYCLES     = 40;
	localparam int N_ROWS           = 19;
	localparam logic [SUM_BITS-1:0] SUM_CEILING = '1;

	typedef enum int {
		PK_FULL,
		PK_SMALL,
		PK_EQUAL,
		PK_ONE_ZERO,
		PK_BOTH_ZERO,
		PK_ONE_BIT,
		PK_EXTREME
	} pair_kind_t;

	typedef struct packed {
		logic [SUM_BITS-1:0] distance;
		logic                overflowed;
	} distance_result_t;

	typedef struct packed {
		logic [VW-1:0]       a;
		logic [VW-1:0]       b;
		logic                last;
		logic                typed;
		logic [SUM_BITS-1:0] distance;
		logic                overflowed;
	} pair_row_t;

	// Expected values are given only where they follow at once from the definition.
	pair_row_t pair_rows [N_ROWS] = '{
		'{16'h0000, 16'h0000, 1'b1, 1'b1, 28'h0000000, 1'b0},
		'{16'h0000, 16'hFFFF, 1'b1, 1'b1, 28'h0010000, 1'b0},
		'{16'hFFFF, 16'h0000, 1'b1, 1'b1, 28'h0010000, 1'b0},
		'{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 28'h0000000, 1'b0},
		'{16'h0001, 16'h0001, 1'b1, 1'b1, 28'h0000000, 1'b0},
		'{16'h0003, 16'h0001, 1'b1, 1'b1, 28'h0008000, 1'b0},
		'{16'h0001, 16'h0002, 1'b1, 1'b1, 28'h0005555, 1'b0},
		'{16'hFFFF, 16'h0001, 1'b1, 1'b0, 28'h0000000, 1'b0},
		'{16'h0001, 16'hFFFF, 1'b0, 1'b0, 28'h0000000, 1'b0},
		'{16'hAAAA, 16'h5555, 1'b0, 1'b0, 28'h0000000, 1'b0},
		'{16'h5555, 16'hAAAA, 1'b1, 1'b0, 28'h0000000, 1'b0},
		'{16'h0000, 16'h0005, 1'b0, 1'b0, 28'h0000000, 1'b0},
		'{16'h0007, 16'h0000, 1'b0, 1'b0, 28'h0000000, 1'b0},
		'{16'h0000, 16'h0000, 1'b0, 1'b0, 28'h0000000, 1'b0},
		'{16'h0009, 16'h0009, 1'b1, 1'b1, 28'h0020000, 1'b0},
		'{16'h8000, 16'h7FFF, 1'b1, 1'b0, 28'h0000000, 1'b0},
		'{16'h00FF, 16'hFF00, 1'b1, 1'b0, 28'h0000000, 1'b0},
		'{16'h1234, 16'h0000, 1'b0, 1'b0, 28'h0000000, 1'b0},
		'{16'h0000, 16'h0000, 1'b1, 1'b1, 28'h0010000, 1'b0}
	};

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [VW-1:0]       a_value;
	logic [VW-1:0]       b_value;
	logic                last_element;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [SUM_BITS-1:0] distance;
	logic                overflowed;

	logic [SUM_BITS-1:0] model_sum = '0;
	logic                model_sat = 1'b0;
	distance_result_t    pending_distances [$];

	int mismatch_count     = 0;
	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	int hold_left          = 0;
	int quiet_cycles       = 0;
	bit hold_request       = 1'b0;

	canberra_distance_accumulator #(
		.VALUE_BITS(VW)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.a_value     (a_value),
		.b_value     (b_value),
		.last_element(last_element),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.distance    (distance),
		.overflowed  (overflowed)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		$display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
	endtask

	// Truncated |a - b| / (a + b) with 16 fractional bits; zero sum counts as one.
	function automatic logic [FRAC_BITS:0] canberra_term(input logic [VW-1:0] a,
			input logic [VW-1:0] b);
		logic [VW-1:0]           diff;
		logic [VW:0]             den;
		logic [VW+FRAC_BITS-1:0] num;
		diff = (a >= b) ? a - b : b - a;
		den  = {1'b0, a} + {1'b0, b};
		num  = {diff, {FRAC_BITS{1'b0}}};
		if (den == '0)
			return '0;
		return (FRAC_BITS + 1)'(num / (VW + FRAC_BITS)'(den));
	endfunction

	// Add one term to the model sum; return 1 with the distance on a last element.
	function automatic bit accumulate_pair(input logic [VW-1:0] a, input logic [VW-1:0] b,
			input logic last, output distance_result_t res);
		logic [SUM_BITS:0] total;
		total = {1'b0, model_sum} + (SUM_BITS + 1)'(canberra_term(a, b));
		if (total > {1'b0, SUM_CEILING}) begin
			total     = {1'b0, SUM_CEILING};
			model_sat = 1'b1;
		end
		model_sum = total[SUM_BITS-1:0];
		res.distance   = model_sum;
		res.overflowed = model_sat;
		if (!last)
			return 1'b0;
		model_sum = '0;
		model_sat = 1'b0;
		return 1'b1;
	endfunction

	task automatic send_pair(input logic [VW-1:0] a, input logic [VW-1:0] b,
			input logic last, input bit typed, input distance_result_t typed_res);
		distance_result_t res;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		a_value      <= a;
		b_value      <= b;
		last_element <= last;
		do
			@(posedge clk);
		while (!in_ready);
		if (accumulate_pair(a, b, last, res))
			pending_distances.push_back(typed ? typed_res : res);
	endtask

	function automatic logic [VW-1:0] extreme_value();
		case ($urandom_range(3))
			0:       return '0;
			1:       return '1;
			2:       return VW'(1);
			default: return {1'b1, {(VW-1){1'b0}}};
		endcase
	endfunction

	task automatic random_pair(input pair_kind_t kind, output logic [VW-1:0] a,
			output logic [VW-1:0] b);
		case (kind)
			PK_SMALL: begin
				a = VW'($urandom_range(255));
				b = VW'($urandom_range(255));
			end
			PK_EQUAL: begin
				a = VW'($urandom);
				b = a;
			end
			PK_ONE_ZERO: begin
				a = '0;
				b = VW'($urandom_range((1 << VW) - 1, 1));
				if ($urandom_range(1))
					{a, b} = {b, a};
			end
			PK_BOTH_ZERO: begin
				a = '0;
				b = '0;
			end
			PK_ONE_BIT: begin
				a = VW'($urandom);
				b = a ^ VW'(1 << $urandom_range(VW - 1));
			end
			PK_EXTREME: begin
				a = extreme_value();
				b = extreme_value();
			end
			default: begin
				a = VW'($urandom);
				b = VW'($urandom);
			end
		endcase
	endtask

	task automatic send_random_vector(inout int count);
		int            len;
		int            pick;
		pair_kind_t    kind;
		logic [VW-1:0] a;
		logic [VW-1:0] b;
		len = ($urandom_range(99) < 85) ? $urandom_range(8, 1) : $urandom_range(64, 9);
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(9);
			kind = (pick < 4) ? PK_FULL : pair_kind_t'(pick - 3);
			random_pair(kind, a, b);
			send_pair(a, b, i == len - 1, 1'b0, '0);
		end
		count += len;
	endtask

	// Receiving side: check each result, then choose the next out_ready.
	always @(posedge clk) begin : receive_side
		distance_result_t oldest;
		if (arst_n && out_valid && out_ready) begin
			if (pending_distances.size() == 0) begin
				report_mismatch("result with nothing pending", '0, 32'(distance));
			end else begin
				oldest = pending_distances.pop_front();
				if (distance !== oldest.distance)
					report_mismatch("distance", 32'(oldest.distance), 32'(distance));
				if (overflowed !== oldest.overflowed)
					report_mismatch("overflowed", 32'(oldest.overflowed), 32'(overflowed));
			end
		end
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int               sender_pcts [4]   = '{0, 71, 0, 37};
		int               receiver_pcts [4] = '{0, 0, 71, 37};
		int               count;
		distance_result_t typed_res;
		logic [VW-1:0]    a;
		logic [VW-1:0]    b;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		a_value      = '0;
		b_value      = '0;
		last_element = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (pair_rows[i]) begin
			typed_res.distance   = pair_rows[i].distance;
			typed_res.overflowed = pair_rows[i].overflowed;
			send_pair(pair_rows[i].a, pair_rows[i].b, pair_rows[i].last,
				pair_rows[i].typed, typed_res);
		end

		for (int phase = 0; phase < 4; phase++) begin
			sender_idle_pct    = sender_pcts[phase];
			receiver_stall_pct = receiver_pcts[phase];
			count = 0;
			while (count < RANDOM_PER_PHASE)
				send_random_vector(count);
		end

		// Hold the receiver off while single-element vectors keep coming.
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		hold_request       = 1'b1;
		for (int i = 0; i < PRESSURE_ITEMS; i++) begin
			random_pair(PK_FULL, a, b);
			send_pair(a, b, 1'b1, 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (pending_distances.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
